[rtl/detection_persistence_tracker_macros.svh]
// Assertion macros shared by the tracker RTL.
`ifndef DETECTION_PERSISTENCE_TRACKER_MACROS_SVH
`define DETECTION_PERSISTENCE_TRACKER_MACROS_SVH

// Flag any cycle out of reset where cond holds.
`define DPT_ASSERT_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
    else $error("dpt assertion failed");

// Flag any cycle out of reset where ante holds and cons does not.
`define DPT_ASSERT_IMPLIES(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("dpt assertion failed");

`endif

[rtl/dpt_pkg.sv]
// Shared types and constants of the detection persistence tracker.
package dpt_pkg;

  localparam int unsigned CoordW = 11;
  localparam int unsigned AngleW = 8;
  localparam int unsigned CountW = 8;
  localparam int unsigned DistW  = 10;
  localparam int unsigned SqW    = 2 * CoordW;
  localparam int unsigned LimW   = 2 * DistW;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 10;

  localparam logic [CfgIdxW-1:0] CFG_DIST_THRESHOLD = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_MAX_COUNT      = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_DECAY_STEP     = 2'd2;

  localparam logic [DistW-1:0]  DIST_THRESHOLD_RST = 10'd20;
  localparam logic [CountW-1:0] MAX_COUNT_RST      = 8'd20;
  localparam logic [CountW-1:0] DECAY_STEP_RST     = 8'd2;

  typedef struct packed {
    logic [CoordW-1:0]        x;
    logic [CoordW-1:0]        y;
    logic [CoordW-1:0]        w;
    logic [CoordW-1:0]        h;
    logic signed [AngleW-1:0] ang;
    logic [CountW-1:0]        cnt;
  } entry_t;

  typedef struct packed {
    entry_t entry;
    logic   seen;
  } slot_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

endpackage

[rtl/dpt_cell.sv]
// One slot of the tracking row: shifts toward the head or loads an entry; a load wins.
module dpt_cell
  import dpt_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  slot_t      nbr_i,
  input  slot_t      load_i,
  output slot_t      slot_o
);

  entry_t entry_q;
  logic   seen_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      entry_q <= load_i.entry;
    end else if (ctrl_i.shift) begin
      entry_q <= nbr_i.entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
    end else if (ctrl_i.load) begin
      seen_q <= load_i.seen;
    end else if (ctrl_i.shift) begin
      seen_q <= nbr_i.seen;
    end
  end

  assign slot_o.entry = entry_q;
  assign slot_o.seen  = seen_q;

endmodule

[rtl/detection_persistence_tracker.sv]
// Top level of the detection persistence tracker.
//
// The tracked boxes sit in a row of TABLE_DEPTH cells, oldest at the head. Every operation
// rotates the occupied cells through one shared unit at the head of the row, so the cost
// grows with the number n of tracked entries: a detection beat squares the distances of
// each entry, then compares and writes it back, then makes the append decision; an
// end-of-frame beat does decay, compaction and best search at one entry a cycle, then
// loads the result register once the previous result has left the output. The input
// stalls while an operation runs; a finished result waits in its own register without
// blocking the next input beat. No result comes out for a detection beat.
`include "detection_persistence_tracker_macros.svh"

module detection_persistence_tracker
  import dpt_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CfgIdxW-1:0]         cfg_idx_i,
  input  logic [CfgDataW-1:0]        cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       mode_i,
  input  logic [CoordW-1:0]          center_x_i,
  input  logic [CoordW-1:0]          center_y_i,
  input  logic [CoordW-1:0]          box_width_i,
  input  logic [CoordW-1:0]          box_height_i,
  input  logic signed [AngleW-1:0]   box_angle_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       found_o,
  output logic [CoordW-1:0]          best_x_o,
  output logic [CoordW-1:0]          best_y_o,
  output logic [CoordW-1:0]          best_width_o,
  output logic [CoordW-1:0]          best_height_o,
  output logic signed [AngleW-1:0]   best_angle_o,
  output logic [CountW-1:0]          best_hits_o,
  output logic                       dropped_o
);

  localparam int unsigned IW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] Full = CW'(TABLE_DEPTH);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SQR  = 3'd1;
  localparam logic [2:0] S_CMP  = 3'd2;
  localparam logic [2:0] S_APP  = 3'd3;
  localparam logic [2:0] S_FEND = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]        state_q;
  logic [CW-1:0]     count_q;
  logic [CW-1:0]     rem_q;
  logic [CW-1:0]     fill_q;
  logic              hit_q;
  logic              drop_q;
  logic              out_valid_q;
  logic [DistW-1:0]  thr_q;
  logic [CountW-1:0] max_q;
  logic [CountW-1:0] decay_q;

  entry_t            item_q;
  logic [LimW-1:0]   lim_q;
  logic [SqW-1:0]    sqx_q;
  logic [SqW-1:0]    sqy_q;
  entry_t            best_q;

  logic              found_q;
  entry_t            out_q;
  logic              dropped_q;

  slot_t             slots [TABLE_DEPTH];
  slot_t             nbrs  [TABLE_DEPTH];
  cell_ctrl_t        ctrls [TABLE_DEPTH];

  logic              shift_all;
  logic              load_en;
  logic [IW-1:0]     load_idx;
  slot_t             load_slot;

  entry_t            head;
  logic              head_seen;
  logic [CoordW-1:0] dx;
  logic [CoordW-1:0] dy;
  logic [SqW:0]      dist2;
  logic              match;
  logic [CountW:0]   cnt_inc;
  logic [CountW-1:0] cnt_hit;
  entry_t            upd_entry;
  logic              keep;
  logic [CountW-1:0] cnt_decay;
  logic [CW-1:0]     fill_next;
  logic [CW-1:0]     count_m1;
  logic [CW-1:0]     fill_m1;
  logic              accept;
  logic              out_load;
  logic              out_held;
  logic              app_full;

  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign out_load = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);
  assign out_held = (state_q == S_OUT) && out_valid_q && out_stall_i;
  assign app_full = (state_q == S_APP) && (count_q == Full);

  // Row of cells; the last cell shifts in an empty slot.
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    if (i == TABLE_DEPTH - 1) begin : g_tail
      assign nbrs[i] = '0;
    end else begin : g_body
      assign nbrs[i] = slots[i+1];
    end
    assign ctrls[i].shift = shift_all;
    assign ctrls[i].load  = load_en && (load_idx == IW'(i));
    dpt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrls[i]),
      .nbr_i  (nbrs[i]),
      .load_i (load_slot),
      .slot_o (slots[i])
    );
  end

  assign head      = slots[0].entry;
  assign head_seen = slots[0].seen;

  assign dx    = (item_q.x > head.x) ? (item_q.x - head.x) : (head.x - item_q.x);
  assign dy    = (item_q.y > head.y) ? (item_q.y - head.y) : (head.y - item_q.y);
  assign dist2 = {1'b0, sqx_q} + {1'b0, sqy_q};
  assign match = dist2 < (SqW+1)'(lim_q);

  assign cnt_inc = {1'b0, head.cnt} + (CountW+1)'(1);
  assign cnt_hit = (cnt_inc < {1'b0, max_q}) ? cnt_inc[CountW-1:0] : max_q;

  always_comb begin
    upd_entry     = item_q;
    upd_entry.cnt = cnt_hit;
  end

  assign keep      = head_seen || (head.cnt > decay_q);
  assign cnt_decay = head_seen ? head.cnt : (head.cnt - decay_q);
  assign fill_next = keep ? fill_q : (fill_q - CW'(1));
  assign count_m1  = count_q - CW'(1);
  assign fill_m1   = fill_q - CW'(1);

  always_comb begin
    shift_all = 1'b0;
    load_en   = 1'b0;
    load_idx  = '0;
    load_slot = '0;
    unique case (state_q)
      S_CMP: begin
        shift_all = 1'b1;
        load_en   = 1'b1;
        load_idx  = count_m1[IW-1:0];
        if (match) begin
          load_slot.entry = upd_entry;
          load_slot.seen  = 1'b1;
        end else begin
          load_slot = slots[0];
        end
      end
      S_APP: begin
        if (!hit_q && (count_q != Full)) begin
          load_en         = 1'b1;
          load_idx        = count_q[IW-1:0];
          load_slot.entry = item_q;
          load_slot.seen  = 1'b1;
        end
      end
      S_FEND: begin
        shift_all           = 1'b1;
        load_en             = keep;
        load_idx            = fill_m1[IW-1:0];
        load_slot.entry     = head;
        load_slot.entry.cnt = cnt_decay;
        load_slot.seen      = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      rem_q       <= '0;
      fill_q      <= '0;
      hit_q       <= 1'b0;
      drop_q      <= 1'b0;
      out_valid_q <= 1'b0;
      thr_q       <= DIST_THRESHOLD_RST;
      max_q       <= MAX_COUNT_RST;
      decay_q     <= DECAY_STEP_RST;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_DIST_THRESHOLD: thr_q   <= cfg_data_i[DistW-1:0];
          CFG_MAX_COUNT:      max_q   <= cfg_data_i[CountW-1:0];
          CFG_DECAY_STEP:     decay_q <= cfg_data_i[CountW-1:0];
          default: begin
          end
        endcase
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            rem_q  <= count_q;
            fill_q <= count_q;
            hit_q  <= 1'b0;
            if (mode_i) begin
              state_q <= (count_q == '0) ? S_OUT : S_FEND;
            end else begin
              state_q <= (count_q == '0) ? S_APP : S_SQR;
            end
          end
        end
        S_SQR: begin
          state_q <= S_CMP;
        end
        S_CMP: begin
          hit_q   <= hit_q || match;
          rem_q   <= rem_q - CW'(1);
          state_q <= (rem_q == CW'(1)) ? S_APP : S_SQR;
        end
        S_APP: begin
          if (!hit_q) begin
            if (count_q == Full) begin
              drop_q <= 1'b1;
            end else begin
              count_q <= count_q + CW'(1);
            end
          end
          state_q <= S_IDLE;
        end
        S_FEND: begin
          rem_q  <= rem_q - CW'(1);
          fill_q <= fill_next;
          if (rem_q == CW'(1)) begin
            count_q <= fill_next;
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            drop_q  <= 1'b0;
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.x   <= center_x_i;
      item_q.y   <= center_y_i;
      item_q.w   <= box_width_i;
      item_q.h   <= box_height_i;
      item_q.ang <= box_angle_i;
      item_q.cnt <= CountW'(1);
      lim_q      <= thr_q * thr_q;
      best_q     <= '0;
    end
    if (state_q == S_SQR) begin
      sqx_q <= dx * dx;
      sqy_q <= dy * dy;
    end
    if ((state_q == S_FEND) && keep && (cnt_decay > best_q.cnt)) begin
      best_q <= {head.x, head.y, head.w, head.h, head.ang, cnt_decay};
    end
    if (out_load) begin
      out_q     <= best_q;
      found_q   <= best_q.cnt > (max_q >> 2);
      dropped_q <= drop_q;
    end
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign found_o       = found_q;
  assign best_x_o      = out_q.x;
  assign best_y_o      = out_q.y;
  assign best_width_o  = out_q.w;
  assign best_height_o = out_q.h;
  assign best_angle_o  = out_q.ang;
  assign best_hits_o   = out_q.cnt;
  assign dropped_o     = dropped_q;

  `DPT_ASSERT_NEVER(a_count_bound, clk_i, rst_ni, count_q > Full)
  `DPT_ASSERT_IMPLIES(a_fill_covers_rem, clk_i, rst_ni, state_q == S_FEND, fill_q >= rem_q)
  `DPT_ASSERT_IMPLIES(a_out_waits, clk_i, rst_ni, out_held, ##1 (state_q == S_OUT))
  `DPT_ASSERT_IMPLIES(a_drop_on_full, clk_i, rst_ni, $rose(drop_q), $past(app_full))

endmodule
